// ===== src/stps_pkg.sv =====
// Shared types and constants for the sparse tree parent search unit.
// No dependencies.
package stps_pkg;

  localparam int POS_W          = 13;
  localparam int VAL_W          = 32;
  localparam int LVL_W          = 2;
  localparam int CNT_W          = 13;
  localparam int RES_W          = 12;
  localparam int CFG_IDX_W      = 2;
  localparam int NUM_COUNT_REGS = 4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HERE,
    ST_NEXT,
    ST_DECIDE
  } state_t;

endpackage

// ===== src/stps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module stps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/sparse_tree_parent_search_unit.sv =====
// Top level of the sparse tree parent search unit.
// Depends on stps_pkg and stps_ram.
//
// Holds one offset array per tree level in a single memory and answers parent
// queries by binary search. A write item (op = 0) leaves busy low. A query item
// (op = 1) runs k halving steps (read offset[pivot], read offset[pivot + 1],
// compare) on the one read port of the offset memory, then a closing step;
// busy is high throughout and done pulses with parent_position in the cycle
// after that step. k is at most floor(log2(node count)) and an exact match
// ends the search early. The next item can be accepted in the cycle that shows
// done.
// The result is shown for exactly one cycle and cannot be held off.
// Configuration writes are always accepted (cfg_ready is tied high).
module sparse_tree_parent_search_unit #(
  parameter int MAX_NODES = 4096,
  parameter int LEVELS    = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           op,
  input  logic [stps_pkg::LVL_W-1:0]     level,
  input  logic [stps_pkg::POS_W-1:0]     entry_position,
  input  logic [stps_pkg::VAL_W-1:0]     entry_value,
  input  logic [stps_pkg::VAL_W-1:0]     query_index,
  output logic                           done,
  output logic [stps_pkg::RES_W-1:0]     parent_position,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [stps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [stps_pkg::CNT_W-1:0]     cfg_data
);

  import stps_pkg::*;

  localparam int ROW_LEN = MAX_NODES + 1;
  localparam int DEPTH   = LEVELS * ROW_LEN;
  localparam int AW      = $clog2(DEPTH);
  localparam int NW      = $clog2(MAX_NODES + 2);

  state_t             state, state_next;
  logic [CNT_W-1:0]   node_count [NUM_COUNT_REGS];
  logic [NW-1:0]      lo, hi, pivot;
  logic [NW:0]        span_sum;
  logic [NW-1:0]      pivot_calc;
  logic [AW-1:0]      base;
  logic [VAL_W-1:0]   q;
  logic [VAL_W-1:0]   here_val;
  logic [VAL_W-1:0]   rd_data;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               wr_en;
  logic               accept;
  logic               level_ok;
  logic               search_more;
  logic [NW-1:0]      count_sat;
  logic [CNT_W-1:0]   count_sel;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign level_ok  = int'(level) < LEVELS;

  assign count_sel = node_count[level];
  assign count_sat = (32'(count_sel) > 32'(MAX_NODES)) ? NW'(MAX_NODES) : NW'(count_sel);

  assign span_sum    = {1'b0, lo} + {1'b0, hi};
  assign pivot_calc  = span_sum[NW:1];
  assign search_more = {1'b0, hi} > ({1'b0, lo} + (NW+1)'(1));

  assign wr_en   = accept && (op == OP_WRITE) && level_ok
                   && (32'(entry_position) < 32'(ROW_LEN));
  assign wr_addr = AW'(level) * AW'(ROW_LEN) + AW'(entry_position);

  stps_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_offsets (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (entry_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = base + AW'(pivot);
    unique case (state)
      ST_IDLE: begin
        if (accept && (op == OP_QUERY)) begin
          state_next = ST_HERE;
        end
      end
      ST_HERE: begin
        rd_addr = base + AW'(pivot_calc);
        if (search_more) begin
          state_next = ST_NEXT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_NEXT: begin
        rd_addr    = base + AW'(pivot) + AW'(1);
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_next = ST_HERE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      for (int i = 0; i < NUM_COUNT_REGS; i++) begin
        node_count[i] <= '0;
      end
    end else begin
      done <= (state == ST_HERE) && !search_more;
      if (cfg_valid && cfg_ready) begin
        node_count[cfg_index] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          lo   <= '0;
          hi   <= level_ok ? count_sat : '0;
          q    <= query_index;
          base <= AW'(level) * AW'(ROW_LEN);
        end
      end
      ST_HERE: begin
        pivot <= pivot_calc;
        if (!search_more) begin
          parent_position <= RES_W'(lo);
        end
      end
      ST_NEXT: begin
        here_val <= rd_data;
      end
      ST_DECIDE: begin
        if (here_val > q) begin
          hi <= pivot;
        end else if (rd_data < q) begin
          lo <= pivot + NW'(1);
        end else if (rd_data == q) begin
          lo <= pivot + NW'(1);
          hi <= pivot + NW'(2);
        end else begin
          lo <= pivot;
          hi <= pivot + NW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/stps_checker.sv =====
// Port-level checks for the sparse tree parent search unit, bound to its top.
// Depends on stps_pkg.
module stps_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           op,
  input logic                           done,
  input logic                           cfg_ready
);

  import stps_pkg::*;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a query in flight");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while still busy");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op == OP_QUERY)) |=> busy)
    else $error("query item did not start a search");

  a_write_quick: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op == OP_WRITE)) |=> (!busy && !done))
    else $error("write item started a search or gave a result");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind sparse_tree_parent_search_unit stps_checker u_stps_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .op        (op),
  .done      (done),
  .cfg_ready (cfg_ready)
);

// ===== dv/sparse_tree_parent_search_unit_tb.sv =====
// Testbench for sparse_tree_parent_search_unit: fills offset entries as searches need them,
// runs parent queries and checks each parent_position against a scoreboard that mirrors the search.
// Depends on stps_pkg and the unit under test.
`timescale 1ns / 100ps

module sparse_tree_parent_search_unit_tb;
  import stps_pkg::*;

  localparam int MAX_NODES      = 4096;
  localparam int LEVELS         = 4;
  localparam int ROW_LEN        = MAX_NODES + 1;
  localparam int DRAIN_CYCLES   = 50;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 8;
  localparam int ITEM_TARGET    = 900;

  class parent_scoreboard;
    bit [VAL_W-1:0] offsets [LEVELS][ROW_LEN];
    bit [CNT_W-1:0] node_count [NUM_COUNT_REGS];
    bit [RES_W-1:0] pending_parents [$];
    int unsigned    errors;

    function void set_count(int idx, bit [CNT_W-1:0] value);
      node_count[idx] = value;
    endfunction

    function int unsigned search_limit(int lvl);
      int unsigned c;
      c = node_count[lvl];
      if (c > MAX_NODES) c = MAX_NODES;
      return c;
    endfunction

    function bit [RES_W-1:0] predict_parent(int lvl, bit [VAL_W-1:0] q);
      int unsigned lo, hi, pivot;
      bit [VAL_W-1:0] here, upper_edge;
      lo = 0;
      hi = search_limit(lvl);
      while (hi > lo + 1) begin
        pivot = (lo + hi) / 2;
        here = offsets[lvl][pivot];
        upper_edge = offsets[lvl][pivot + 1];
        if (here > q) begin
          hi = pivot;
        end else if (upper_edge < q) begin
          lo = pivot + 1;
        end else if (upper_edge == q) begin
          lo = pivot + 1;
          hi = lo + 1;
        end else begin
          lo = pivot;
          hi = lo + 1;
        end
      end
      return lo[RES_W-1:0];
    endfunction

    function void note_item(logic item_op, bit [LVL_W-1:0] lvl, bit [POS_W-1:0] pos,
                            bit [VAL_W-1:0] value, bit [VAL_W-1:0] q);
      if (item_op == OP_WRITE) begin
        if (pos < ROW_LEN) offsets[lvl][pos] = value;
      end else begin
        pending_parents.push_back(predict_parent(lvl, q));
      end
    endfunction

    function void check_result(logic [RES_W-1:0] got);
      bit [RES_W-1:0] want;
      if (pending_parents.size() == 0) begin
        $error("parent_position: no result expected, got %0d", got);
        errors++;
        return;
      end
      want = pending_parents.pop_front();
      if (got !== want) begin
        $error("parent_position: expected %0d, got %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 op;
  logic [LVL_W-1:0]     level;
  logic [POS_W-1:0]     entry_position;
  logic [VAL_W-1:0]     entry_value;
  logic [VAL_W-1:0]     query_index;
  logic                 done;
  logic [RES_W-1:0]     parent_position;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_W-1:0]     cfg_data;

  parent_scoreboard sb;
  bit               written [LEVELS][ROW_LEN];
  int unsigned      curve_base [LEVELS];
  int unsigned      curve_step [LEVELS];
  int unsigned      items_sent;
  bit               no_gaps;
  int unsigned      stall_cycles;

  sparse_tree_parent_search_unit #(
    .MAX_NODES(MAX_NODES),
    .LEVELS   (LEVELS)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .level          (level),
    .entry_position (entry_position),
    .entry_value    (entry_value),
    .query_index    (query_index),
    .done           (done),
    .parent_position(parent_position),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(parent_position);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // all tasks start and end just after a falling edge
  task automatic send_item(input logic item_op, input bit [LVL_W-1:0] lvl,
                           input bit [POS_W-1:0] pos, input bit [VAL_W-1:0] value,
                           input bit [VAL_W-1:0] q);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if ($urandom_range(0, 19) == 0) no_gaps = !no_gaps;
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start          = 1'b1;
    op             = item_op;
    level          = lvl;
    entry_position = pos;
    entry_value    = value;
    query_index    = q;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(item_op, lvl, pos, value, q);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_entry(input int lvl, input bit [POS_W-1:0] pos,
                             input bit [VAL_W-1:0] value);
    send_item(OP_WRITE, lvl[LVL_W-1:0], pos, value, $urandom);
    if (pos < ROW_LEN) written[lvl][pos] = 1'b1;
  endtask

  // unwritten entries follow a nondecreasing curve of their level
  function automatic bit [VAL_W-1:0] row_value(int lvl, int pos);
    longint unsigned v;
    if (written[lvl][pos]) return sb.offsets[lvl][pos];
    v = 64'(curve_base[lvl]) + ((64'(pos) * 64'(curve_step[lvl])) >> 1);
    return v[VAL_W-1:0];
  endfunction

  // writes every entry the search for q will read
  task automatic prepare_path(input int lvl, input bit [VAL_W-1:0] q);
    int unsigned lo, hi, pivot;
    bit [VAL_W-1:0] here, upper_edge;
    lo = 0;
    hi = sb.search_limit(lvl);
    while (hi > lo + 1) begin
      pivot = (lo + hi) / 2;
      here = row_value(lvl, pivot);
      upper_edge = row_value(lvl, pivot + 1);
      if (!written[lvl][pivot]) write_entry(lvl, POS_W'(pivot), here);
      if (!written[lvl][pivot + 1]) write_entry(lvl, POS_W'(pivot + 1), upper_edge);
      if (here > q) begin
        hi = pivot;
      end else if (upper_edge < q) begin
        lo = pivot + 1;
      end else if (upper_edge == q) begin
        lo = pivot + 1;
        hi = lo + 1;
      end else begin
        lo = pivot;
        hi = lo + 1;
      end
    end
  endtask

  task automatic ask_parent(input int lvl, input bit [VAL_W-1:0] q);
    prepare_path(lvl, q);
    send_item(OP_QUERY, lvl[LVL_W-1:0], POS_W'($urandom_range(0, 8191)), $urandom, q);
  endtask

  task automatic write_count(input int idx, input bit [CNT_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx[CFG_IDX_W-1:0];
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_count(idx, value);
    @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (sb.pending_parents.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apply_counts(input bit [CNT_W-1:0] c0, c1, c2, c3);
    bit [CNT_W-1:0] want [NUM_COUNT_REGS];
    want = '{c0, c1, c2, c3};
    for (int i = 0; i < NUM_COUNT_REGS; i++) write_count(i, want[i]);
    cfg_valid = 1'b0;
  endtask

  function automatic bit [CNT_W-1:0] draw_count();
    case ($urandom_range(0, 9))
      0:       return CNT_W'(MAX_NODES);
      1:       return CNT_W'($urandom_range(MAX_NODES + 1, 8191));
      2:       return CNT_W'($urandom_range(0, 1));
      default: return CNT_W'($urandom_range(2, 40));
    endcase
  endfunction

  function automatic bit [VAL_W-1:0] pick_probe(int lvl);
    int unsigned k;
    bit [VAL_W-1:0] base;
    k = $urandom_range(0, sb.search_limit(lvl));
    base = row_value(lvl, k);
    case ($urandom_range(0, 7))
      0, 1:    return base;
      2:       return base - 1;
      3:       return base + 1;
      4:       return 32'h0000_0000;
      5:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_item();
    int lvl;
    int unsigned r, p;
    bit [VAL_W-1:0] lower, upper, value;
    lvl = $urandom_range(0, LEVELS - 1);
    r = $urandom_range(0, 99);
    if (r < 55) begin
      ask_parent(lvl, pick_probe(lvl));
    end else if (r < 90) begin
      // keep the row nondecreasing
      p = $urandom_range(0, sb.search_limit(lvl));
      lower = (p == 0) ? 32'h0 : row_value(lvl, p - 1);
      upper = (p + 1 < ROW_LEN) ? row_value(lvl, p + 1) : 32'hFFFF_FFFF;
      case ($urandom_range(0, 3))
        0:       value = lower;
        1:       value = upper;
        default: value = $urandom_range(lower, upper);
      endcase
      write_entry(lvl, POS_W'(p), value);
    end else begin
      write_entry(lvl, POS_W'($urandom_range(ROW_LEN, 8191)), $urandom);
    end
  endtask

  initial begin
    sb             = new();
    rst            = 1'b1;
    start          = 1'b0;
    op             = OP_WRITE;
    level          = '0;
    entry_position = '0;
    entry_value    = '0;
    query_index    = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    no_gaps        = 1'b0;
    items_sent     = 0;
    curve_base[0]  = 32'd0;
    curve_step[0]  = $urandom_range(1, 3);
    curve_base[1]  = 32'hFFFE_0000;
    curve_step[1]  = $urandom_range(1, 62);
    curve_base[2]  = 32'd1000;
    curve_step[2]  = $urandom_range(1, 32'h0008_0000);
    curve_base[3]  = 32'h8000_0000;
    curve_step[3]  = $urandom_range(1, 32'h0000_3FFF);
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // queries on empty and single-node levels never read the rows
    apply_counts(13'd0, 13'd1, 13'd0, 13'd1);
    ask_parent(0, 32'h0000_0000);
    ask_parent(0, 32'hFFFF_FFFF);
    ask_parent(1, 32'h5555_AAAA);
    ask_parent(3, 32'hAAAA_5555);
    write_entry(3, 13'd8191, 32'hFFFF_FFFF);
    write_entry(2, 13'd4097, 32'h0000_0000);
    write_entry(0, 13'd0, 32'h0000_0000);
    drain();

    // full-size and saturated counts, smallest searching counts
    apply_counts(CNT_W'(MAX_NODES), 13'd8191, 13'd2, 13'd3);
    ask_parent(0, row_value(0, MAX_NODES));
    ask_parent(0, row_value(0, MAX_NODES - 1));
    ask_parent(0, 32'hFFFF_FFFF);
    ask_parent(0, row_value(0, 2048));
    ask_parent(1, 32'h0000_0000);
    ask_parent(1, row_value(1, MAX_NODES) + 1);
    ask_parent(2, row_value(2, 1));
    ask_parent(2, row_value(2, 2));
    ask_parent(3, row_value(3, 0));
    ask_parent(3, row_value(3, 3));

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      if (phase == PHASES - 1) begin
        apply_counts(13'd8191, 13'd0, CNT_W'(MAX_NODES), 13'd1);
      end else begin
        apply_counts(draw_count(), draw_count(), draw_count(), draw_count());
      end
      while (items_sent < ITEM_TARGET * (phase + 1) / PHASES) random_item();
    end
    drain();

    if (sb.errors == 0 && sb.pending_parents.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/stps_pkg.sv
src/stps_ram.sv
src/sparse_tree_parent_search_unit.sv
src/stps_checker.sv
dv/sparse_tree_parent_search_unit_tb.sv
